// ----- sv/sepq_pkg.sv -----
// shared constants and codes for the sorted event priority queue
package sepq_pkg;

	localparam int TIME_W         = 32;
	localparam int STATUS_W       = 2;
	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_TAG_BITS   = 8;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// ----- sv/sepq_ram.sv -----
// single-port-write, single-port-read event store with registered read data
module sepq_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 40,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/sepq_ctrl.sv -----
// queue sequencer: circular sorted list in memory, head pop and tail-side insert shift
module sepq_ctrl import sepq_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int TAG_BITS = DEF_TAG_BITS,
	parameter int ADDR_W   = $clog2(CAPACITY),
	parameter int CNT_W    = $clog2(CAPACITY + 1),
	parameter int ENT_W    = TIME_W + TAG_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_kind,
	input  logic [TIME_W-1:0]   in_time,
	input  logic [TAG_BITS-1:0] in_tag,
	output logic                ram_we,
	output logic [ADDR_W-1:0]   ram_waddr,
	output logic [ENT_W-1:0]    ram_wdata,
	output logic                ram_re,
	output logic [ADDR_W-1:0]   ram_raddr,
	input  logic [ENT_W-1:0]    ram_rdata,
	output logic                res_valid,
	input  logic                res_ready,
	output logic [STATUS_W-1:0] res_status,
	output logic [TIME_W-1:0]   res_time,
	output logic [TAG_BITS-1:0] res_tag,
	output logic [CNT_W-1:0]    res_count
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_SCAN = 5'b00100,
		S_PUT  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   head_q, head_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [ADDR_W-1:0]   idx_q, idx_d;
	logic [TIME_W-1:0]   time_q, time_d;
	logic [TAG_BITS-1:0] tag_q, tag_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic [TIME_W-1:0]   rtime_q, rtime_d;
	logic [TAG_BITS-1:0] rtag_q, rtag_d;

	logic [ADDR_W:0]     cnt_last;
	logic [ADDR_W:0]     idx_next;
	logic [ADDR_W:0]     idx_prev;
	logic [ADDR_W-1:0]   head_inc;
	logic [TIME_W-1:0]   rd_time;
	logic                rd_later;

	function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] base,
		input logic [ADDR_W:0] offs);
		logic [ADDR_W:0] sum;
		sum = {1'b0, base} + offs;
		if (sum >= (ADDR_W+1)'(CAPACITY)) begin
			sum = sum - (ADDR_W+1)'(CAPACITY);
		end
		return sum[ADDR_W-1:0];
	endfunction

	assign cnt_last = (ADDR_W+1)'(count_q) - (ADDR_W+1)'(1);
	assign idx_next = {1'b0, idx_q} + (ADDR_W+1)'(1);
	assign idx_prev = {1'b0, idx_q} - (ADDR_W+1)'(1);
	assign head_inc = phys(head_q, (ADDR_W+1)'(1));
	assign rd_time  = ram_rdata[TIME_W-1:0];
	assign rd_later = rd_time > time_q;

	assign in_ready   = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res_status = status_q;
	assign res_time   = rtime_q;
	assign res_tag    = rtag_q;
	assign res_count  = count_q;

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		idx_d     = idx_q;
		time_d    = time_q;
		tag_d     = tag_q;
		status_d  = status_q;
		rtime_d   = rtime_q;
		rtag_d    = rtag_q;
		ram_we    = 1'b0;
		ram_waddr = head_q;
		ram_wdata = {tag_q, time_q};
		ram_re    = 1'b0;
		ram_raddr = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					time_d   = in_time;
					tag_d    = in_tag;
					status_d = ST_OK;
					rtime_d  = '0;
					rtag_d   = '0;
					if (in_kind == KIND_INSERT) begin
						if (count_q == CNT_W'(CAPACITY)) begin
							status_d = ST_FULL;
							state_d  = S_DONE;
						end else if (count_q == '0) begin
							ram_we    = 1'b1;
							ram_waddr = head_q;
							ram_wdata = {in_tag, in_time};
							count_d   = count_q + CNT_W'(1);
							state_d   = S_DONE;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = phys(head_q, cnt_last);
							idx_d     = cnt_last[ADDR_W-1:0];
							state_d   = S_SCAN;
						end
					end else begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
							state_d  = S_DONE;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = head_q;
							state_d   = S_RD;
						end
					end
				end
			end
			S_RD: begin
				rtime_d = rd_time;
				rtag_d  = ram_rdata[ENT_W-1:TIME_W];
				head_d  = head_inc;
				count_d = count_q - CNT_W'(1);
				state_d = S_DONE;
			end
			S_SCAN: begin
				ram_we    = 1'b1;
				ram_waddr = phys(head_q, idx_next);
				if (rd_later) begin
					// move the later event up one slot, keep walking down
					ram_wdata = ram_rdata;
					if (idx_q == '0) begin
						state_d = S_PUT;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = phys(head_q, idx_prev);
						idx_d     = idx_prev[ADDR_W-1:0];
					end
				end else begin
					ram_wdata = {tag_q, time_q};
					count_d   = count_q + CNT_W'(1);
					state_d   = S_DONE;
				end
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = head_q;
				ram_wdata = {tag_q, time_q};
				count_d   = count_q + CNT_W'(1);
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		time_q   <= time_d;
		tag_q    <= tag_d;
		status_q <= status_d;
		rtime_q  <= rtime_d;
		rtag_q   <= rtag_d;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("stored count beyond capacity");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ((state_q == S_IDLE && in_kind == KIND_REMOVE) || state_q == S_RD
		|| state_q == S_DONE)))
		else $error("memory write outside an insert");

	a_pop_read: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_kind == KIND_REMOVE && count_q != '0)
		|=> (state_q == S_RD && head_q == $past(head_q)))
		else $error("remove did not go to the head read");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_status)
		&& $stable(res_time) && $stable(res_tag) && $stable(res_count)))
		else $error("result changed while held");

endmodule

// ----- sv/sepq_out.sv -----
// result register between the sequencer and the master side
module sepq_out import sepq_pkg::*; #(
	parameter int TAG_BITS = DEF_TAG_BITS,
	parameter int CNT_W    = $clog2(DEF_CAPACITY + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [STATUS_W-1:0] in_status,
	input  logic [TIME_W-1:0]   in_time,
	input  logic [TAG_BITS-1:0] in_tag,
	input  logic [CNT_W-1:0]    in_count,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] out_status,
	output logic [TIME_W-1:0]   out_time,
	output logic [TAG_BITS-1:0] out_tag,
	output logic [CNT_W-1:0]    out_count
);

	logic                valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [TIME_W-1:0]   time_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [CNT_W-1:0]    count_q;
	logic                load;

	assign in_ready = !valid_q || out_ready;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= in_status;
			time_q   <= in_time;
			tag_q    <= in_tag;
			count_q  <= in_count;
		end
	end

	assign out_valid  = valid_q;
	assign out_status = status_q;
	assign out_time   = time_q;
	assign out_tag    = tag_q;
	assign out_count  = count_q;

endmodule

// ----- sv/sorted_event_priority_queue_unit.sv -----
// sorted event priority queue, top level with stream ports
//
//  group | dir | tuser         | tdata (lowest bit up)
//  s_*   | in  | kind          | event_time, event_tag
//  m_*   | out | status        | removed_time, removed_tag, count
//
// remove: one head read, then the result
// insert: a tail read, then each stored event later than the new one moves up a slot (one shift per cycle)
// insert into empty, insert when full, remove when empty: no memory read, straight to the result
// reset clears the state, count, head and scan index; the event memory needs no clearing
// a stalled master side holds one result and the next item is taken meanwhile
module sorted_event_priority_queue_unit import sepq_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int TAG_BITS = DEF_TAG_BITS,
	localparam int CNT_W   = $clog2(CAPACITY + 1),
	localparam int IN_W    = ((TIME_W + TAG_BITS + 7) / 8) * 8,
	localparam int OUT_W   = ((TIME_W + TAG_BITS + CNT_W + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [0:0]           s_tuser,  // kind
	input  logic [IN_W-1:0]      s_tdata,  // event_time, event_tag
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [STATUS_W-1:0]  m_tuser,  // status
	output logic [OUT_W-1:0]     m_tdata   // removed_time, removed_tag, count
);

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int ENT_W  = TIME_W + TAG_BITS;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [ENT_W-1:0]    ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [ENT_W-1:0]    ram_rdata;

	logic                res_valid;
	logic                res_ready;
	logic [STATUS_W-1:0] res_status;
	logic [TIME_W-1:0]   res_time;
	logic [TAG_BITS-1:0] res_tag;
	logic [CNT_W-1:0]    res_count;

	logic [TIME_W-1:0]   out_time;
	logic [TAG_BITS-1:0] out_tag;
	logic [CNT_W-1:0]    out_count;

	sepq_ram #(
		.DEPTH  (CAPACITY),
		.WIDTH  (ENT_W),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sepq_ctrl #(
		.CAPACITY (CAPACITY),
		.TAG_BITS (TAG_BITS),
		.ADDR_W   (ADDR_W),
		.CNT_W    (CNT_W),
		.ENT_W    (ENT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (s_tuser[0]),
		.in_time    (s_tdata[TIME_W-1:0]),
		.in_tag     (s_tdata[TIME_W +: TAG_BITS]),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_status (res_status),
		.res_time   (res_time),
		.res_tag    (res_tag),
		.res_count  (res_count)
	);

	sepq_out #(
		.TAG_BITS (TAG_BITS),
		.CNT_W    (CNT_W)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (res_valid),
		.in_ready   (res_ready),
		.in_status  (res_status),
		.in_time    (res_time),
		.in_tag     (res_tag),
		.in_count   (res_count),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_time   (out_time),
		.out_tag    (out_tag),
		.out_count  (out_count)
	);

	assign m_tdata = OUT_W'({out_count, out_tag, out_time});

endmodule
